### rtl/lav_pkg.sv
// ----------------------------------------------------------------------------
// lav_pkg
// Shared constants and types for the look-at view matrix pipeline.
// ----------------------------------------------------------------------------
package lav_pkg;

  localparam int FRACTION_BITS_DEF = 16;
  localparam int COORD_W           = 32;
  // leading one of the largest magnitude sits here after scaling
  localparam int NORM_TOP          = 30;

  localparam logic signed [COORD_W-1:0] SAT_MAX = 32'sh7FFF_FFFF;
  localparam logic signed [COORD_W-1:0] SAT_MIN = 32'sh8000_0000;

  // column codes
  localparam logic [1:0] COL_X = 2'd0;
  localparam logic [1:0] COL_Y = 2'd1;
  localparam logic [1:0] COL_Z = 2'd2;
  localparam logic [1:0] COL_T = 2'd3;

  typedef struct packed {
    logic valid;
    logic degen;
  } lav_ctl_t;

endpackage

### rtl/lav_if.sv
// ----------------------------------------------------------------------------
// lav_if
// Valid/ready channels: eye and target points in, matrix columns out.
// ----------------------------------------------------------------------------
interface lav_eye_if;
  logic                                valid;
  logic                                ready;
  logic signed [lav_pkg::COORD_W-1:0]  eye_x;
  logic signed [lav_pkg::COORD_W-1:0]  eye_y;
  logic signed [lav_pkg::COORD_W-1:0]  eye_z;
  logic signed [lav_pkg::COORD_W-1:0]  target_x;
  logic signed [lav_pkg::COORD_W-1:0]  target_y;
  logic signed [lav_pkg::COORD_W-1:0]  target_z;

  modport source (output valid, eye_x, eye_y, eye_z, target_x, target_y, target_z,
                  input ready);
  modport sink (input valid, eye_x, eye_y, eye_z, target_x, target_y, target_z,
                output ready);
endinterface

interface lav_col_if;
  logic                                valid;
  logic                                ready;
  logic [1:0]                          column_index;
  logic signed [lav_pkg::COORD_W-1:0]  row0_value;
  logic signed [lav_pkg::COORD_W-1:0]  row1_value;
  logic signed [lav_pkg::COORD_W-1:0]  row2_value;
  logic signed [lav_pkg::COORD_W-1:0]  row3_value;
  logic                                last_column;
  logic                                degenerate;

  modport source (output valid, column_index, row0_value, row1_value, row2_value,
                  row3_value, last_column, degenerate, input ready);
  modport sink (input valid, column_index, row0_value, row1_value, row2_value,
                row3_value, last_column, degenerate, output ready);
endinterface

### rtl/lav_norm.sv
// ----------------------------------------------------------------------------
// lav_norm
// Pipelined 3-vector normalisation: scale, sum of squares, bit-per-stage
// square root, then three restoring dividers one quotient bit per stage.
// ----------------------------------------------------------------------------
module lav_norm #(
  parameter int FRACTION_BITS = lav_pkg::FRACTION_BITS_DEF,
  parameter int VW            = 33,
  parameter int SW            = 96
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            en,
  input  lav_pkg::lav_ctl_t               in_ctl,
  input  logic signed [VW-1:0]            in_vec [3],
  input  logic [SW-1:0]                   in_side,
  output lav_pkg::lav_ctl_t               out_ctl,
  output logic signed [FRACTION_BITS+1:0] out_vec [3],
  output logic [SW-1:0]                   out_side
);

  localparam int QW       = FRACTION_BITS + 2;
  localparam int AW       = lav_pkg::NORM_TOP + 1;
  localparam int NW       = FRACTION_BITS + AW + 1;
  localparam int PW       = $clog2(VW);
  localparam int SQW      = 2 * AW;
  localparam int SUMW     = SQW + 2;
  localparam int STEPS    = SUMW / 2;
  localparam int LW       = STEPS;
  localparam int S_ABS    = 1;
  localparam int S_MSB    = 2;
  localparam int S_SHF    = 3;
  localparam int S_SQ     = 4;
  localparam int S_SUM    = 5;
  localparam int S_RT_END = S_SUM + STEPS;
  localparam int S_DP     = S_RT_END + 1;
  localparam int S_DV_END = S_DP + QW;
  localparam int L        = S_DV_END + 1;

  lav_pkg::lav_ctl_t ctl_p  [0:L];
  logic [SW-1:0]     side_p [0:L];
  logic [2:0]        neg_p  [S_ABS:L-1];
  logic              zero_p [S_MSB:L-1];
  logic [VW-1:0]     abs_p  [S_ABS:S_MSB][3];
  logic [PW-1:0]     msb_q;
  logic [AW-1:0]     an_p   [S_SHF:S_DP-1][3];
  logic [SQW-1:0]    sq_q   [3];
  logic [SUMW-1:0]   s_p    [S_SUM:S_RT_END-1];
  logic [SUMW-1:0]   r_p    [S_SUM:S_RT_END];
  logic [LW-1:0]     len_p  [S_DP:S_DV_END-1];
  logic [LW-1:0]     rem_p  [S_DP:S_DV_END-1][3];
  logic [QW-1:0]     q_p    [S_DP:S_DV_END][3];

  logic [VW-1:0]                 m;
  logic [PW-1:0]                 msb;
  logic [VW+lav_pkg::NORM_TOP-1:0] ext [3];
  logic [LW-1:0]                 len;
  logic [NW-1:0]                 numer [3];

  assign ctl_p[0]  = in_ctl;
  assign side_p[0] = in_side;

  // control and side data ride along every stage
  for (genvar k = 1; k < L; k++) begin : g_ctl
    always_ff @(posedge clk) begin
      if (rst) begin
        ctl_p[k] <= '0;
      end else if (en) begin
        ctl_p[k] <= ctl_p[k-1];
      end
    end
  end

  for (genvar k = 1; k <= L; k++) begin : g_side
    always_ff @(posedge clk) begin
      if (en) begin
        side_p[k] <= side_p[k-1];
      end
    end
  end

  for (genvar k = S_ABS + 1; k < L; k++) begin : g_neg
    always_ff @(posedge clk) begin
      if (en) begin
        neg_p[k] <= neg_p[k-1];
      end
    end
  end

  for (genvar k = S_MSB + 1; k < L; k++) begin : g_zero
    always_ff @(posedge clk) begin
      if (en) begin
        zero_p[k] <= zero_p[k-1];
      end
    end
  end

  for (genvar k = S_SHF + 1; k < S_DP; k++) begin : g_an
    always_ff @(posedge clk) begin
      if (en) begin
        an_p[k] <= an_p[k-1];
      end
    end
  end

  // magnitudes
  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        neg_p[S_ABS][i] <= in_vec[i][VW-1];
        abs_p[S_ABS][i] <= in_vec[i][VW-1] ? $unsigned(-in_vec[i]) : $unsigned(in_vec[i]);
      end
    end
  end

  // top set bit of the OR equals that of the largest magnitude
  always_comb begin
    m   = abs_p[S_ABS][0] | abs_p[S_ABS][1] | abs_p[S_ABS][2];
    msb = '0;
    for (int b = 0; b < VW; b++) begin
      if (m[b]) msb = PW'(b);
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      abs_p[S_MSB]  <= abs_p[S_ABS];
      msb_q         <= msb;
      zero_p[S_MSB] <= (m == '0);
    end
  end

  // scale so the largest magnitude has its top bit at NORM_TOP
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      ext[i] = {abs_p[S_MSB][i], {lav_pkg::NORM_TOP{1'b0}}} >> msb_q;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        an_p[S_SHF][i] <= ext[i][AW-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        sq_q[i] <= SQW'(an_p[S_SHF][i]) * SQW'(an_p[S_SHF][i]);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s_p[S_SUM] <= SUMW'(sq_q[0]) + SUMW'(sq_q[1]) + SUMW'(sq_q[2]);
      r_p[S_SUM] <= '0;
    end
  end

  // integer square root, one result bit per stage
  for (genvar k = 1; k <= STEPS; k++) begin : g_root
    localparam logic [SUMW-1:0] BIT = SUMW'(1) << (SUMW - 2 * k);
    logic [SUMW-1:0] trial;
    logic            fits;

    assign trial = r_p[S_SUM+k-1] + BIT;
    assign fits  = s_p[S_SUM+k-1] >= trial;

    always_ff @(posedge clk) begin
      if (en) begin
        r_p[S_SUM+k] <= fits ? (r_p[S_SUM+k-1] >> 1) + BIT : r_p[S_SUM+k-1] >> 1;
      end
    end

    if (k < STEPS) begin : g_rem
      always_ff @(posedge clk) begin
        if (en) begin
          s_p[S_SUM+k] <= fits ? s_p[S_SUM+k-1] - trial : s_p[S_SUM+k-1];
        end
      end
    end
  end

  // rounded dividend; the high part is already below the length
  assign len = r_p[S_RT_END][LW-1:0];

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      numer[i] = (NW'(an_p[S_DP-1][i]) << FRACTION_BITS) + NW'(len >> 1);
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      len_p[S_DP] <= len;
      for (int i = 0; i < 3; i++) begin
        rem_p[S_DP][i] <= LW'(numer[i][NW-1:QW]);
        q_p[S_DP][i]   <= numer[i][QW-1:0];
      end
    end
  end

  for (genvar j = 1; j <= QW; j++) begin : g_div
    localparam int ID = S_DP + j;
    logic [LW:0] t  [3];
    logic [2:0]  ge;

    always_comb begin
      for (int i = 0; i < 3; i++) begin
        t[i]  = {rem_p[ID-1][i], q_p[ID-1][i][QW-1]};
        ge[i] = t[i] >= {1'b0, len_p[ID-1]};
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        for (int i = 0; i < 3; i++) begin
          q_p[ID][i] <= {q_p[ID-1][i][QW-2:0], ge[i]};
        end
      end
    end

    if (j < QW) begin : g_rem
      always_ff @(posedge clk) begin
        if (en) begin
          len_p[ID] <= len_p[ID-1];
          for (int i = 0; i < 3; i++) begin
            rem_p[ID][i] <= ge[i] ? LW'(t[i] - {1'b0, len_p[ID-1]}) : LW'(t[i]);
          end
        end
      end
    end
  end

  // sign back on, zero vector stays zero and flags
  always_ff @(posedge clk) begin
    if (rst) begin
      ctl_p[L] <= '0;
    end else if (en) begin
      ctl_p[L].valid <= ctl_p[L-1].valid;
      ctl_p[L].degen <= ctl_p[L-1].degen | zero_p[L-1];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        if (zero_p[L-1]) begin
          out_vec[i] <= '0;
        end else if (neg_p[L-1][i]) begin
          out_vec[i] <= -$signed(q_p[S_DV_END][i]);
        end else begin
          out_vec[i] <= $signed(q_p[S_DV_END][i]);
        end
      end
    end
  end

  assign out_ctl  = ctl_p[L];
  assign out_side = side_p[L];

endmodule

### rtl/lav_dot.sv
// ----------------------------------------------------------------------------
// lav_dot
// Translation column: dot products with the eye point, rounded to nearest
// (ties up) and saturated. Basis vectors travel alongside.
// ----------------------------------------------------------------------------
module lav_dot #(
  parameter int FRACTION_BITS = lav_pkg::FRACTION_BITS_DEF
) (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  en,
  input  lav_pkg::lav_ctl_t                     in_ctl,
  input  logic signed [FRACTION_BITS+1:0]       in_r [3],
  input  logic signed [FRACTION_BITS+1:0]       in_u [3],
  input  logic signed [FRACTION_BITS+1:0]       in_f [3],
  input  logic signed [lav_pkg::COORD_W-1:0]    in_eye [3],
  output lav_pkg::lav_ctl_t                     out_ctl,
  output logic signed [FRACTION_BITS+1:0]       out_r [3],
  output logic signed [FRACTION_BITS+1:0]       out_u [3],
  output logic signed [FRACTION_BITS+1:0]       out_f [3],
  output logic signed [lav_pkg::COORD_W-1:0]    out_t [3]
);

  localparam int UW  = FRACTION_BITS + 2;
  localparam int PRW = UW + lav_pkg::COORD_W;
  localparam int XW  = PRW + 3;

  lav_pkg::lav_ctl_t      ctl1, ctl2;
  logic signed [UW-1:0]   r1 [3], u1 [3], f1 [3];
  logic signed [UW-1:0]   r2 [3], u2 [3], f2 [3];
  logic signed [PRW-1:0]  pr_q [3][3];
  logic signed [XW-1:0]   x_q [3];
  logic signed [XW:0]     half_c;
  logic signed [XW:0]     y [3];
  logic signed [XW:0]     sh [3];

  always_ff @(posedge clk) begin
    if (rst) begin
      ctl1    <= '0;
      ctl2    <= '0;
      out_ctl <= '0;
    end else if (en) begin
      ctl1    <= in_ctl;
      ctl2    <= ctl1;
      out_ctl <= ctl2;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      r1 <= in_r;  u1 <= in_u;  f1 <= in_f;
      r2 <= r1;    u2 <= u1;    f2 <= f1;
      out_r <= r2; out_u <= u2; out_f <= f2;
      for (int i = 0; i < 3; i++) begin
        pr_q[0][i] <= PRW'(in_r[i]) * PRW'(in_eye[i]);
        pr_q[1][i] <= PRW'(in_u[i]) * PRW'(in_eye[i]);
        pr_q[2][i] <= PRW'(in_f[i]) * PRW'(in_eye[i]);
      end
      x_q[0] <= -(XW'(pr_q[0][0]) + XW'(pr_q[0][1]) + XW'(pr_q[0][2]));
      x_q[1] <= -(XW'(pr_q[1][0]) + XW'(pr_q[1][1]) + XW'(pr_q[1][2]));
      x_q[2] <= XW'(pr_q[2][0]) + XW'(pr_q[2][1]) + XW'(pr_q[2][2]);
    end
  end

  assign half_c = (XW+1)'(1) << (FRACTION_BITS - 1);

  // floor((x + half) / 2^F) is an arithmetic shift
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      y[i]  = (XW+1)'(x_q[i]) + half_c;
      sh[i] = y[i] >>> FRACTION_BITS;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        if (sh[i] > lav_pkg::SAT_MAX) begin
          out_t[i] <= lav_pkg::SAT_MAX;
        end else if (sh[i] < lav_pkg::SAT_MIN) begin
          out_t[i] <= lav_pkg::SAT_MIN;
        end else begin
          out_t[i] <= sh[i][lav_pkg::COORD_W-1:0];
        end
      end
    end
  end

endmodule

### rtl/lav_ser.sv
// ----------------------------------------------------------------------------
// lav_ser
// Column serialiser: holds one finished matrix and sends it one column word
// at a time, taking the next matrix as the last column leaves.
// ----------------------------------------------------------------------------
module lav_ser #(
  parameter int FRACTION_BITS = lav_pkg::FRACTION_BITS_DEF
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  lav_pkg::lav_ctl_t                    in_ctl,
  input  logic signed [FRACTION_BITS+1:0]      in_r [3],
  input  logic signed [FRACTION_BITS+1:0]      in_u [3],
  input  logic signed [FRACTION_BITS+1:0]      in_f [3],
  input  logic signed [lav_pkg::COORD_W-1:0]   in_t [3],
  output logic                                 take,
  lav_col_if.source                            columns
);

  localparam int CW = lav_pkg::COORD_W;
  localparam logic signed [CW-1:0] ONE = CW'(1) << FRACTION_BITS;

  logic                           busy;
  logic [1:0]                     cnt;
  logic                           degen_q;
  logic signed [FRACTION_BITS+1:0] r_q [3], u_q [3], f_q [3];
  logic signed [CW-1:0]           t_q [3];

  assign take = !busy || (columns.ready && cnt == lav_pkg::COL_T);

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt  <= lav_pkg::COL_X;
    end else if (take) begin
      busy <= in_ctl.valid;
      cnt  <= lav_pkg::COL_X;
    end else if (columns.ready) begin
      cnt <= cnt + 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (take && in_ctl.valid) begin
      degen_q <= in_ctl.degen;
      r_q     <= in_r;
      u_q     <= in_u;
      f_q     <= in_f;
      t_q     <= in_t;
    end
  end

  assign columns.valid        = busy;
  assign columns.column_index = cnt;
  assign columns.last_column  = (cnt == lav_pkg::COL_T);
  assign columns.degenerate   = degen_q;
  assign columns.row3_value   = (cnt == lav_pkg::COL_T) ? ONE : '0;

  always_comb begin
    case (cnt)
      lav_pkg::COL_X: begin
        columns.row0_value = CW'(r_q[0]);
        columns.row1_value = CW'(u_q[0]);
        columns.row2_value = -CW'(f_q[0]);
      end
      lav_pkg::COL_Y: begin
        columns.row0_value = CW'(r_q[1]);
        columns.row1_value = CW'(u_q[1]);
        columns.row2_value = -CW'(f_q[1]);
      end
      lav_pkg::COL_Z: begin
        columns.row0_value = CW'(r_q[2]);
        columns.row1_value = CW'(u_q[2]);
        columns.row2_value = -CW'(f_q[2]);
      end
      lav_pkg::COL_T: begin
        columns.row0_value = t_q[0];
        columns.row1_value = t_q[1];
        columns.row2_value = t_q[2];
      end
      default: begin
        columns.row0_value = '0;
        columns.row1_value = '0;
        columns.row2_value = '0;
      end
    endcase
  end

endmodule

### rtl/look_at_view_matrix.sv
// ----------------------------------------------------------------------------
// look_at_view_matrix
// Right-handed look-at view matrix in signed fixed point, streamed out as
// four column words per eye/target pair.
// ----------------------------------------------------------------------------
//  channel   dir  word                                   handshake
//  points    in   eye_x/y/z, target_x/y/z (signed Q)     valid/ready
//  columns   out  column_index, row0..3, last, degen     valid/ready
//
//  Sustained throughput is set by the four column words per pair.
//  The pipeline advances as a whole; it halts only while its last stage
//  holds a matrix and the serialiser still has columns to send.
//  Synchronous reset clears valid bits and the serialiser; data is not reset.
// ----------------------------------------------------------------------------
module look_at_view_matrix #(
  parameter int FRACTION_BITS = lav_pkg::FRACTION_BITS_DEF
) (
  input  logic       clk,
  input  logic       rst,
  lav_eye_if.sink    points,
  lav_col_if.source  columns
);

  localparam int UW  = FRACTION_BITS + 2;
  localparam int CW  = lav_pkg::COORD_W;
  localparam int DW  = CW + 1;
  localparam int EW  = 3 * CW;
  localparam int SW2 = EW + 3 * UW;
  localparam int SW3 = EW + 6 * UW;
  localparam int XW  = 2 * UW + 1;

  lav_pkg::lav_ctl_t a_ctl, n1_ctl, n2_ctl, x1_ctl, x2_ctl, n3_ctl, dot_ctl;

  logic                  en;
  logic                  take;
  logic signed [DW-1:0]  d_q [3];
  logic [EW-1:0]         a_eye, n1_eye;
  logic signed [UW-1:0]  f1 [3], r2 [3], u3 [3];
  logic signed [UW:0]    rr [3];
  logic [SW2-1:0]        n2_in_side, n2_side;
  logic signed [UW-1:0]  n2_f [3];
  logic signed [2*UW-1:0] pr_q [6];
  logic [SW3-1:0]        x1_side, x2_side, n3_side;
  logic signed [XW-1:0]  ur_q [3];
  logic signed [UW-1:0]  n3_f [3], n3_r [3];
  logic signed [CW-1:0]  n3_eye [3];
  logic signed [UW-1:0]  dot_r [3], dot_u [3], dot_f [3];
  logic signed [CW-1:0]  dot_t [3];

  assign en           = !dot_ctl.valid || take;
  assign points.ready = en;

  // target - eye, exact in one extra bit
  always_ff @(posedge clk) begin
    if (rst) begin
      a_ctl <= '0;
    end else if (en) begin
      a_ctl.valid <= points.valid;
      a_ctl.degen <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      d_q[0] <= DW'(points.target_x) - DW'(points.eye_x);
      d_q[1] <= DW'(points.target_y) - DW'(points.eye_y);
      d_q[2] <= DW'(points.target_z) - DW'(points.eye_z);
      a_eye  <= {points.eye_x, points.eye_y, points.eye_z};
    end
  end

  lav_norm #(.FRACTION_BITS(FRACTION_BITS), .VW(DW), .SW(EW)) u_fwd (
    .clk, .rst, .en,
    .in_ctl(a_ctl), .in_vec(d_q), .in_side(a_eye),
    .out_ctl(n1_ctl), .out_vec(f1), .out_side(n1_eye)
  );

  // forward x world up
  assign rr[0]      = -(UW+1)'(f1[2]);
  assign rr[1]      = '0;
  assign rr[2]      = (UW+1)'(f1[0]);
  assign n2_in_side = {n1_eye, f1[0], f1[1], f1[2]};

  lav_norm #(.FRACTION_BITS(FRACTION_BITS), .VW(UW+1), .SW(SW2)) u_right (
    .clk, .rst, .en,
    .in_ctl(n1_ctl), .in_vec(rr), .in_side(n2_in_side),
    .out_ctl(n2_ctl), .out_vec(r2), .out_side(n2_side)
  );

  for (genvar i = 0; i < 3; i++) begin : g_unpack
    assign n2_f[i]   = $signed(n2_side[3*UW-1-i*UW -: UW]);
    assign n3_eye[i] = $signed(n3_side[SW3-1-i*CW -: CW]);
    assign n3_f[i]   = $signed(n3_side[6*UW-1-i*UW -: UW]);
    assign n3_r[i]   = $signed(n3_side[3*UW-1-i*UW -: UW]);
  end

  // right x forward, products then differences
  always_ff @(posedge clk) begin
    if (rst) begin
      x1_ctl <= '0;
      x2_ctl <= '0;
    end else if (en) begin
      x1_ctl <= n2_ctl;
      x2_ctl <= x1_ctl;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      pr_q[0] <= (2*UW)'(r2[1]) * (2*UW)'(n2_f[2]);
      pr_q[1] <= (2*UW)'(r2[2]) * (2*UW)'(n2_f[1]);
      pr_q[2] <= (2*UW)'(r2[2]) * (2*UW)'(n2_f[0]);
      pr_q[3] <= (2*UW)'(r2[0]) * (2*UW)'(n2_f[2]);
      pr_q[4] <= (2*UW)'(r2[0]) * (2*UW)'(n2_f[1]);
      pr_q[5] <= (2*UW)'(r2[1]) * (2*UW)'(n2_f[0]);
      x1_side <= {n2_side, r2[0], r2[1], r2[2]};
      ur_q[0] <= XW'(pr_q[0]) - XW'(pr_q[1]);
      ur_q[1] <= XW'(pr_q[2]) - XW'(pr_q[3]);
      ur_q[2] <= XW'(pr_q[4]) - XW'(pr_q[5]);
      x2_side <= x1_side;
    end
  end

  lav_norm #(.FRACTION_BITS(FRACTION_BITS), .VW(XW), .SW(SW3)) u_up (
    .clk, .rst, .en,
    .in_ctl(x2_ctl), .in_vec(ur_q), .in_side(x2_side),
    .out_ctl(n3_ctl), .out_vec(u3), .out_side(n3_side)
  );

  lav_dot #(.FRACTION_BITS(FRACTION_BITS)) u_dot (
    .clk, .rst, .en,
    .in_ctl(n3_ctl), .in_r(n3_r), .in_u(u3), .in_f(n3_f), .in_eye(n3_eye),
    .out_ctl(dot_ctl), .out_r(dot_r), .out_u(dot_u), .out_f(dot_f), .out_t(dot_t)
  );

  lav_ser #(.FRACTION_BITS(FRACTION_BITS)) u_ser (
    .clk, .rst,
    .in_ctl(dot_ctl), .in_r(dot_r), .in_u(dot_u), .in_f(dot_f), .in_t(dot_t),
    .take, .columns
  );

  // columns of one matrix come out in order
  a_col_order: assert property (@(posedge clk) disable iff (rst)
    (columns.valid && columns.ready && !columns.last_column) |=>
      (columns.valid && columns.column_index == $past(columns.column_index) + 2'd1))
    else $error("column order broken");

  // input only held off while a word is waiting
  a_stall_cause: assert property (@(posedge clk) disable iff (rst)
    !points.ready |-> columns.valid)
    else $error("input stalled with no output pending");

  // flag is the same on every column of one matrix
  a_degen_run: assert property (@(posedge clk) disable iff (rst)
    (columns.valid && columns.ready && !columns.last_column) |=> $stable(columns.degenerate))
    else $error("degenerate flag changed within a matrix");

endmodule
